// File: hdl/mts_pkg.sv
package mts_pkg;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned COUNT_W     = $clog2(STACK_DEPTH + 1);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_read;
	} dp_status_t;

endpackage

// File: hdl/mts_req_if.sv
interface mts_req_if import mts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	cmd_t                     cmd;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink (input valid, input cmd, input push_value, output ready);
endinterface

// File: hdl/mts_res_if.sv
interface mts_res_if import mts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] min_value;
	logic [COUNT_W-1:0]       element_count;
	logic                     is_empty;
	err_t                     error_code;

	modport source (
		output valid, output top_value, output min_value, output element_count,
		output is_empty, output error_code, input ready
	);
	modport sink (
		input valid, input top_value, input min_value, input element_count,
		input is_empty, input error_code, output ready
	);
endinterface

// File: hdl/mts_ram.sv
module mts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/mts_datapath.sv
module mts_datapath import mts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  dp_cmd,
	output dp_status_t               dp_status,
	input  cmd_t                     cmd,
	input  logic signed [DATA_W-1:0] push_value,
	output logic signed [DATA_W-1:0] top_value,
	output logic signed [DATA_W-1:0] min_value,
	output logic [COUNT_W-1:0]       element_count,
	output logic                     is_empty,
	output err_t                     error_code
);
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       mcount_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] min_q;
	err_t                     err_q;

	logic               full;
	logic               empty;
	logic               push_ok;
	logic               pop_ok;
	logic               min_push;
	logic               min_pop;
	logic [COUNT_W-1:0] v_rd_count;
	logic [COUNT_W-1:0] m_rd_count;
	logic [DATA_W-1:0]  v_rdata;
	logic [DATA_W-1:0]  m_rdata;

	assign full     = (count_q == COUNT_W'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign push_ok  = dp_cmd.take && (cmd == CMD_PUSH) && !full;
	assign pop_ok   = dp_cmd.take && (cmd == CMD_POP) && !empty;
	assign min_push = (mcount_q == '0) || (push_value <= min_q);
	assign min_pop  = (mcount_q != '0) && (min_q == top_q);

	assign dp_status.pop_read = (cmd == CMD_POP) && !empty;

	// new tops sit one below the shrunken counts
	assign v_rd_count = count_q - COUNT_W'(2);
	assign m_rd_count = mcount_q - (min_pop ? COUNT_W'(2) : COUNT_W'(1));

	mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (push_value),
		.raddr (v_rd_count[ADDR_W-1:0]),
		.rdata (v_rdata)
	);

	mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (push_ok && min_push),
		.waddr (mcount_q[ADDR_W-1:0]),
		.wdata (push_value),
		.raddr (m_rd_count[ADDR_W-1:0]),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mcount_q <= '0;
			err_q    <= ERR_OK;
		end else if (dp_cmd.take) begin
			if (push_ok) begin
				count_q <= count_q + COUNT_W'(1);
				if (min_push) begin
					mcount_q <= mcount_q + COUNT_W'(1);
				end
			end else if (pop_ok) begin
				count_q <= count_q - COUNT_W'(1);
				if (min_pop) begin
					mcount_q <= mcount_q - COUNT_W'(1);
				end
			end
			if (cmd == CMD_PUSH) begin
				err_q <= full ? ERR_FULL : ERR_OK;
			end else begin
				err_q <= empty ? ERR_EMPTY : ERR_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			top_q <= push_value;
			if (min_push) begin
				min_q <= push_value;
			end
		end else if (dp_cmd.load) begin
			top_q <= v_rdata;
			min_q <= m_rdata;
		end
	end

	assign top_value     = empty ? '0 : top_q;
	assign min_value     = empty ? '0 : min_q;
	assign element_count = count_q;
	assign is_empty      = empty;
	assign error_code    = err_q;
endmodule

// File: hdl/mts_ctrl.sv
module mts_ctrl import mts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t dp_status,
	output dp_cmd_t    dp_cmd
);
	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = dp_status.pop_read ? ST_LOAD : ST_RESULT;
				end
			end
			ST_LOAD: begin
				state_next = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		dp_cmd.take = 1'b0;
		dp_cmd.load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				dp_cmd.take = in_valid;
			end
			ST_LOAD: begin
				dp_cmd.load = 1'b1;
			end
			ST_RESULT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end
endmodule

// File: hdl/min_tracking_stack.sv
// push or error: IDLE straight to RESULT; a valid pop passes through LOAD (stack ram read) first
// one request at a time: a new one is taken only in IDLE, after the last result is accepted
// the LOAD step on a pop comes from the registered read that refills the cached top registers
// reset: arst_n clears the counts, error code and controller; stack rams hold no reset
// and only entries below the counts ever reach the outputs
module min_tracking_stack import mts_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	mts_req_if.sink   request,
	mts_res_if.source result
);
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	mts_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.dp_status     (dp_status),
		.cmd           (request.cmd),
		.push_value    (request.push_value),
		.top_value     (result.top_value),
		.min_value     (result.min_value),
		.element_count (result.element_count),
		.is_empty      (result.is_empty),
		.error_code    (result.error_code)
	);

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.element_count <= COUNT_W'(STACK_DEPTH))
		else $error("element count beyond stack depth");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> !request.ready)
		else $error("request taken while previous one in flight");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_empty |-> result.min_value <= result.top_value)
		else $error("minimum above top value");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_empty |->
		result.top_value == '0 && result.min_value == '0)
		else $error("empty stack reports nonzero values");
`endif
endmodule

// File: dv/tb_min_tracking_stack.sv
module tb_min_tracking_stack;
	import mts_pkg::*;

	localparam int STALL_LIMIT = 500;
	localparam int DRAIN_CYCLES = 10;
	localparam int GAPPED_ITEMS = 1400;

	typedef struct packed {
		logic signed [DATA_W-1:0] top;
		logic signed [DATA_W-1:0] min;
		logic [COUNT_W-1:0]       count;
		logic                     empty;
		err_t                     err;
	} stack_status_t;

	typedef struct {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
		bit                       typed;
		stack_status_t            want;
	} directed_row_t;

	logic clk;
	logic arst_n;

	mts_req_if req_ch ();
	mts_res_if res_ch ();

	min_tracking_stack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	logic signed [DATA_W-1:0] shadow_values [STACK_DEPTH];
	logic signed [DATA_W-1:0] shadow_mins [STACK_DEPTH];
	int unsigned              shadow_depth;
	int unsigned              shadow_min_depth;

	stack_status_t status_q[$];
	directed_row_t directed_rows[$];

	bit            req_fire;
	bit            res_fire;
	bit            no_gaps;
	bit            cur_typed;
	stack_status_t cur_want;
	stack_status_t predicted;
	stack_status_t observed;
	stack_status_t oldest;
	int            stalled_cycles;
	int            error_count;
	int            push_count;
	int            pop_count;
	int            full_rejects;
	int            empty_rejects;
	int            sent_items;
	int            ready_stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic stack_status_t apply_stack_op(cmd_t op, logic signed [DATA_W-1:0] value);
		stack_status_t s;
		s.err = ERR_OK;
		if (op == CMD_PUSH) begin
			if (shadow_depth >= STACK_DEPTH) begin
				s.err = ERR_FULL;
			end else begin
				if (shadow_min_depth == 0 ||
						(shadow_min_depth < STACK_DEPTH &&
						value <= shadow_mins[shadow_min_depth-1])) begin
					shadow_mins[shadow_min_depth] = value;
					shadow_min_depth++;
				end
				shadow_values[shadow_depth] = value;
				shadow_depth++;
			end
		end else begin
			if (shadow_depth == 0) begin
				s.err = ERR_EMPTY;
			end else begin
				if (shadow_min_depth > 0 &&
						shadow_mins[shadow_min_depth-1] == shadow_values[shadow_depth-1])
					shadow_min_depth--;
				shadow_depth--;
			end
		end
		s.top   = (shadow_depth > 0) ? shadow_values[shadow_depth-1] : '0;
		s.min   = (shadow_depth > 0 && shadow_min_depth > 0) ?
			shadow_mins[shadow_min_depth-1] : '0;
		s.count = COUNT_W'(shadow_depth);
		s.empty = (shadow_depth == 0);
		return s;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
			4: return (shadow_depth > 0) ? shadow_values[shadow_depth-1] : 32'sd0;
			5: return (shadow_min_depth > 0) ? shadow_mins[shadow_min_depth-1] : 32'sd0;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic compare_status(stack_status_t want, stack_status_t got);
		if (got.top !== want.top) begin
			$error("top_value: expected %0d, got %0d", want.top, got.top);
			error_count++;
		end
		if (got.min !== want.min) begin
			$error("min_value: expected %0d, got %0d", want.min, got.min);
			error_count++;
		end
		if (got.count !== want.count) begin
			$error("element_count: expected %0d, got %0d", want.count, got.count);
			error_count++;
		end
		if (got.empty !== want.empty) begin
			$error("is_empty: expected %0d, got %0d", want.empty, got.empty);
			error_count++;
		end
		if (got.err !== want.err) begin
			$error("error_code: expected %0d, got %0d", want.err, got.err);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		res_fire = arst_n && res_ch.valid && res_ch.ready;
		if (res_fire) begin
			observed.top   = res_ch.top_value;
			observed.min   = res_ch.min_value;
			observed.count = res_ch.element_count;
			observed.empty = res_ch.is_empty;
			observed.err   = res_ch.error_code;
			if (status_q.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				oldest = status_q.pop_front();
				compare_status(oldest, observed);
			end
		end
		if (req_fire) begin
			predicted = apply_stack_op(req_ch.cmd, req_ch.push_value);
			status_q.push_back(cur_typed ? cur_want : predicted);
			if (req_ch.cmd == CMD_PUSH)
				push_count++;
			else
				pop_count++;
			if (predicted.err == ERR_FULL)
				full_rejects++;
			if (predicted.err == ERR_EMPTY)
				empty_rejects++;
		end
		if (!arst_n || req_fire || res_fire)
			stalled_cycles = 0;
		else
			stalled_cycles++;
	end

	initial begin
		res_ch.ready = 1'b0;
		ready_stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (ready_stall_left > 0) begin
				res_ch.ready <= 1'b0;
				ready_stall_left--;
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				ready_stall_left = $urandom_range(1, 8) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stalled_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_request(cmd_t op, logic signed [DATA_W-1:0] value,
			bit typed, stack_status_t want);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		cur_want  = want;
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= op;
		req_ch.push_value <= value;
		sent_items++;
		do @(negedge clk); while (!req_fire);
	endtask

	task automatic send_random(cmd_t op);
		send_request(op, pick_value(), 1'b0, '0);
	endtask

	task automatic add_row(cmd_t op, logic signed [DATA_W-1:0] value, bit typed,
			logic signed [DATA_W-1:0] top, logic signed [DATA_W-1:0] min,
			int count, logic empty, err_t err);
		directed_row_t row;
		row.cmd        = op;
		row.value      = value;
		row.typed      = typed;
		row.want.top   = top;
		row.want.min   = min;
		row.want.count = COUNT_W'(count);
		row.want.empty = empty;
		row.want.err   = err;
		directed_rows.push_back(row);
	endtask

	// fill to full, overrun, drain to empty, underrun
	task automatic full_sweep();
		while (shadow_depth < STACK_DEPTH)
			send_random(CMD_PUSH);
		repeat (2) send_random(CMD_PUSH);
		while (shadow_depth > 0)
			send_random(CMD_POP);
		repeat (2) send_random(CMD_POP);
	endtask

	initial begin
		int seg_len;
		int push_bias;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_PUSH;
		req_ch.push_value = '0;
		no_gaps           = 1'b0;
		cur_typed         = 1'b0;
		cur_want          = '0;
		shadow_depth      = 0;
		shadow_min_depth  = 0;
		stalled_cycles    = 0;
		error_count       = 0;
		push_count        = 0;
		pop_count         = 0;
		full_rejects      = 0;
		empty_rejects     = 0;
		sent_items        = 0;

		add_row(CMD_POP,  32'sd0,           1, 32'sd0, 32'sd0, 0, 1'b1, ERR_EMPTY);
		add_row(CMD_PUSH, 32'sh7fffffff,    1, 32'sh7fffffff, 32'sh7fffffff, 1, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'sh80000000,    1, 32'sh80000000, 32'sh80000000, 2, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'sh80000000,    1, 32'sh80000000, 32'sh80000000, 3, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sh7fffffff,    1, 32'sh80000000, 32'sh80000000, 2, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sh12345678,    1, 32'sh7fffffff, 32'sh7fffffff, 1, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_PUSH, -32'sd1,          0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'sd1,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_PUSH, -32'sd1,          0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'sh55555555,    0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_PUSH, 32'shaaaaaaaa,    0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'shffffffff,    0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           0, 0, 0, 0, 1'b0, ERR_OK);
		add_row(CMD_POP,  32'sd0,           1, 32'sd0, 32'sd0, 0, 1'b1, ERR_OK);
		add_row(CMD_POP,  32'sh7fffffff,    1, 32'sd0, 32'sd0, 0, 1'b1, ERR_EMPTY);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].cmd, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);

		full_sweep();

		// random walks with a push-heavy, balanced or pop-heavy mix per segment
		while (sent_items < GAPPED_ITEMS) begin
			seg_len = $urandom_range(30, 200);
			case ($urandom_range(0, 2))
				0: push_bias = 85;
				1: push_bias = 50;
				default: push_bias = 15;
			endcase
			repeat (seg_len)
				send_random(($urandom_range(1, 100) <= push_bias) ? CMD_PUSH : CMD_POP);
		end

		no_gaps = 1'b1;
		full_sweep();

		req_ch.valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d push, %0d pop", push_count + pop_count,
			push_count, pop_count);
		$display("rejected %0d pushes on full and %0d pops on empty", full_rejects,
			empty_rejects);
		if (error_count == 0 && status_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
